/* rtl/core/gmsw_pkg.sv */
// shared types, defaults and compare helpers for the gray morphology window block
// used by gmsw_line_cell, gmsw_tap_cell and gray_morphology_square_window
package gmsw_pkg;

   localparam int DEF_MAX_RADIUS = 3;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int PIX_W    = 8;
   localparam int CSR_W    = 11;
   localparam int RADIUS_W = 2;

   typedef enum logic [1:0] {
      CSR_MODE   = 2'd0,
      CSR_RADIUS = 2'd1,
      CSR_WIDTH  = 2'd2,
      CSR_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } line_ctl_type;

   typedef struct packed {
      logic shift_en;
      logic want_tog;
      logic mode;
   } tap_ctl_type;

   // dilation keeps the larger value, erosion the smaller
   function automatic logic [PIX_W-1:0] pick(input logic m, input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
      logic [PIX_W-1:0] r;
      if (m) begin
         r = (a > b) ? a : b;
      end else begin
         r = (a < b) ? a : b;
      end
      return r;
   endfunction

   function automatic logic [PIX_W-1:0] ident(input logic m);
      return m ? {PIX_W{1'b0}} : {PIX_W{1'b1}};
   endfunction

endpackage

/* rtl/core/gmsw_line_cell.sv */
// one line store of the row chain: holds one earlier row, passes its read data on
// depends on gmsw_pkg
module gmsw_line_cell #(
   parameter int DEPTH = gmsw_pkg::DEF_MAX_WIDTH,
   parameter int AW    = $clog2(gmsw_pkg::DEF_MAX_WIDTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  gmsw_pkg::line_ctl_type    ctl,
   input  logic [AW-1:0]             rd_addr,
   input  logic [AW-1:0]             wr_addr,
   input  logic [gmsw_pkg::PIX_W-1:0] wr_data,
   output logic [gmsw_pkg::PIX_W-1:0] rd_data
);
   import gmsw_pkg::*;

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_ff;
   logic [PIX_W-1:0] bypd_ff;
   logic             byp_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_ff   <= mem[rd_addr];
         bypd_ff <= wr_data;
      end
   end

   // same column written and read at one edge (one pixel per row)
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (ctl.rd_en) begin
         byp_ff <= ctl.wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = byp_ff ? bypd_ff : rd_ff;

endmodule

/* rtl/core/gmsw_tap_cell.sv */
// one horizontal tap: holds a column result with its row tag, shifts it to the next tap
// depends on gmsw_pkg
module gmsw_tap_cell #(
   parameter int CELL_INDEX = 0,
   parameter int YW         = 11,
   parameter int RW         = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gmsw_pkg::tap_ctl_type      ctl,
   input  logic [YW-1:0]              want_tag,
   input  logic [RW-1:0]              radius,
   input  logic                       d_valid,
   input  logic [gmsw_pkg::PIX_W-1:0] d_value,
   input  logic [YW-1:0]              d_tag,
   input  logic                       d_tog,
   output logic                       q_valid,
   output logic [gmsw_pkg::PIX_W-1:0] q_value,
   output logic [YW-1:0]              q_tag,
   output logic                       q_tog,
   output logic [gmsw_pkg::PIX_W-1:0] masked
);
   import gmsw_pkg::*;

   logic             valid_ff;
   logic [PIX_W-1:0] value_ff;
   logic [YW-1:0]    tag_ff;
   logic             tog_ff;
   logic             hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.shift_en) begin
         valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift_en) begin
         value_ff <= d_value;
         tag_ff   <= d_tag;
         tog_ff   <= d_tog;
      end
   end

   // a tap counts only inside the window and on the centre row of this frame
   assign hit = valid_ff && (tog_ff == ctl.want_tog) && (tag_ff == want_tag)
                && (CELL_INDEX <= 2 * int'(radius));

   assign masked  = hit ? value_ff : ident(ctl.mode);
   assign q_valid = valid_ff;
   assign q_value = value_ff;
   assign q_tag   = tag_ff;
   assign q_tog   = tog_ff;

endmodule

/* rtl/core/gray_morphology_square_window.sv */
// gray erosion / dilation over a clipped square window, streamed in raster order
// depends on gmsw_pkg, gmsw_line_cell, gmsw_tap_cell
//
// usage:
//   req_*: one item per transfer, tdata = pixel, tuser = pad (flush tick)
//   rsp_*: one result pixel per transfer, tlast marks the frame's final pixel
//   csr_*: write mode, radius, width, height while idle; taken at the next frame start
// a frame is W*H pixels followed by r*W+r pad items; each item past that lag gives
// one result for the next pixel in raster order. a pad before the frame's pixels
// are all in is dropped without a result.
// throughput: one item per cycle unless rsp_tready stalls the pipe; each of the
// 2*MAX_RADIUS line stores does one read and one write per cycle, the tap chain
// shifts once per item. the item that causes a result passes through stage 1,
// the tap chain and the output register before the result appears on rsp_*.
// a stalled rsp_tready freezes the whole pipe and drops req_tready in the same
// cycle; the held result stays on rsp_*.
// reset clears the counters, the tap chain valid bits and the registers to
// mode erosion, radius 1, 1024 x 1024; line stores hold stale rows that are masked.
module gray_morphology_square_window #(
   parameter int MAX_RADIUS = gmsw_pkg::DEF_MAX_RADIUS,
   parameter int MAX_WIDTH  = gmsw_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gmsw_pkg::DEF_MAX_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] in_pixel
   input  logic                          req_tuser,   // [0] pad
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [7:0] out_pixel
   output logic                          rsp_tlast,
   input  logic                          csr_wen,
   input  logic [1:0]                    csr_index,
   input  logic [gmsw_pkg::CSR_W-1:0]    csr_wdata
);
   import gmsw_pkg::*;

   localparam int NLINE = 2 * MAX_RADIUS;
   localparam int NTAP  = 2 * MAX_RADIUS + 1;
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int YW    = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 1);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int LW    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

   // registers as written
   logic             cfg_mode_ff;
   logic [RADIUS_W-1:0] cfg_radius_ff;
   logic [CSR_W-1:0] cfg_width_ff;
   logic [CSR_W-1:0] cfg_height_ff;

   // per frame copies and counters
   logic          first_ff, first_in;
   logic          tog_ff, tog_in;
   logic          act_mode_ff;
   logic [RW-1:0] act_r_ff;
   logic [WW-1:0] act_w_ff;
   logic [HW-1:0] act_h_ff;
   logic [LW-1:0] lag_ff, lag_in;
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [XW-1:0] oc_ff, oc_in;
   logic [HW-1:0] or_ff, or_in;

   logic          m_cur;
   logic [RW-1:0] r_cur, r_sat;
   logic [WW-1:0] w_cur, w_sat;
   logic [HW-1:0] h_cur, h_sat;
   logic [LW-1:0] lag_cur, lag_calc;
   logic          adv, accept, in_frame, item_go, emit, last;

   // pipeline stage 1: item with its line store reads
   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [XW-1:0]    s1_x_ff;
   logic [YW-1:0]    s1_y_ff;
   logic             s1_emit_ff, s1_last_ff, s1_mode_ff, s1_tog_ff;
   logic [HW-1:0]    s1_or_ff;
   logic [RW-1:0]    s1_r_ff;
   logic [HW-1:0]    s1_h_ff;

   // pipeline stage 2: column result in the tap chain
   logic             s2_valid_ff;
   logic             s2_emit_ff, s2_last_ff, s2_mode_ff, s2_tog_ff;
   logic [HW-1:0]    s2_or_ff;
   logic [RW-1:0]    s2_r_ff;

   logic             out_valid_ff;
   logic [PIX_W-1:0] out_pix_ff;
   logic             out_last_ff;

   logic [PIX_W-1:0] line_q [NLINE];
   logic [PIX_W-1:0] vert;
   logic [PIX_W-1:0] horz;
   line_ctl_type     lctl;
   tap_ctl_type      tctl;
   logic [YW-1:0]    want_tag;

   logic             tap_v [NTAP+1];
   logic [PIX_W-1:0] tap_d [NTAP+1];
   logic [YW-1:0]    tap_t [NTAP+1];
   logic             tap_g [NTAP+1];
   logic [PIX_W-1:0] tap_m [NTAP];

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_mode_ff   <= 1'b0;
         cfg_radius_ff <= RADIUS_W'(1);
         cfg_width_ff  <= CSR_W'(1024);
         cfg_height_ff <= CSR_W'(1024);
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:   cfg_mode_ff   <= csr_wdata[0];
            CSR_RADIUS: cfg_radius_ff <= csr_wdata[RADIUS_W-1:0];
            CSR_WIDTH:  cfg_width_ff  <= csr_wdata;
            CSR_HEIGHT: cfg_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp registers into the supported range
   always_comb begin
      r_sat = (int'(cfg_radius_ff) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_radius_ff);
      if (cfg_width_ff == '0) begin
         w_sat = WW'(1);
      end else if (int'(cfg_width_ff) > MAX_WIDTH) begin
         w_sat = WW'(MAX_WIDTH);
      end else begin
         w_sat = WW'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         h_sat = HW'(1);
      end else if (int'(cfg_height_ff) > MAX_HEIGHT) begin
         h_sat = HW'(MAX_HEIGHT);
      end else begin
         h_sat = HW'(cfg_height_ff);
      end
      lag_calc = LW'(LW'(r_sat) * LW'(w_sat)) + LW'(r_sat);
   end

   always_comb begin
      m_cur    = first_ff ? cfg_mode_ff : act_mode_ff;
      r_cur    = first_ff ? r_sat : act_r_ff;
      w_cur    = first_ff ? w_sat : act_w_ff;
      h_cur    = first_ff ? h_sat : act_h_ff;
      lag_cur  = first_ff ? lag_calc : lag_ff;
      in_frame = y_ff < YW'(h_cur);
      item_go  = accept && (!in_frame || !req_tuser);
      emit     = (lag_cur == '0);
      last     = emit && (or_ff == h_cur - HW'(1)) && (WW'(oc_ff) == w_cur - WW'(1));

      first_in = first_ff;
      tog_in   = tog_ff;
      lag_in   = lag_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      oc_in    = oc_ff;
      or_in    = or_ff;
      if (item_go) begin
         first_in = 1'b0;
         lag_in   = emit ? '0 : lag_cur - LW'(1);
         if (WW'(x_ff) + WW'(1) == w_cur) begin
            x_in = '0;
            y_in = y_ff + YW'(1);
         end else begin
            x_in = x_ff + XW'(1);
         end
         if (emit) begin
            if (WW'(oc_ff) + WW'(1) == w_cur) begin
               oc_in = '0;
               or_in = or_ff + HW'(1);
            end else begin
               oc_in = oc_ff + XW'(1);
            end
         end
         if (last) begin
            first_in = 1'b1;
            tog_in   = ~tog_ff;
            lag_in   = '0;
            x_in     = '0;
            y_in     = '0;
            oc_in    = '0;
            or_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff    <= 1'b1;
         tog_ff      <= 1'b0;
         lag_ff      <= '0;
         x_ff        <= '0;
         y_ff        <= '0;
         oc_ff       <= '0;
         or_ff       <= '0;
         act_mode_ff <= 1'b0;
         act_r_ff    <= RW'(1);
         act_w_ff    <= WW'(MAX_WIDTH);
         act_h_ff    <= HW'(MAX_HEIGHT);
      end else begin
         first_ff <= first_in;
         tog_ff   <= tog_in;
         lag_ff   <= lag_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         oc_ff    <= oc_in;
         or_ff    <= or_in;
         if (accept && first_ff) begin
            act_mode_ff <= m_cur;
            act_r_ff    <= r_cur;
            act_w_ff    <= w_cur;
            act_h_ff    <= h_cur;
         end
      end
   end

   // control valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= item_go;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff && s2_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (item_go) begin
         s1_pix_ff  <= req_tdata;
         s1_x_ff    <= x_ff;
         s1_y_ff    <= y_ff;
         s1_emit_ff <= emit;
         s1_last_ff <= last;
         s1_or_ff   <= or_ff;
         s1_mode_ff <= m_cur;
         s1_r_ff    <= r_cur;
         s1_h_ff    <= h_cur;
         s1_tog_ff  <= tog_ff;
      end
      if (adv && s1_valid_ff) begin
         s2_emit_ff <= s1_emit_ff;
         s2_last_ff <= s1_last_ff;
         s2_or_ff   <= s1_or_ff;
         s2_mode_ff <= s1_mode_ff;
         s2_r_ff    <= s1_r_ff;
         s2_tog_ff  <= s1_tog_ff;
      end
      if (adv && s2_valid_ff && s2_emit_ff) begin
         out_pix_ff  <= horz;
         out_last_ff <= s2_last_ff;
      end
   end

   // row chain: line i holds row y-(i+1) at the current column
   assign lctl.rd_en = item_go;
   assign lctl.wr_en = adv && s1_valid_ff;

   for (genvar i = 0; i < NLINE; i++) begin : g_line
      gmsw_line_cell #(
         .DEPTH (MAX_WIDTH),
         .AW    (XW)
      ) u_line (
         .clock   (clock),
         .reset   (reset),
         .ctl     (lctl),
         .rd_addr (x_ff),
         .wr_addr (s1_x_ff),
         .wr_data ((i == 0) ? s1_pix_ff : line_q[(i == 0) ? 0 : i - 1]),
         .rd_data (line_q[i])
      );
   end

   // column reduction over rows clipped to the image
   always_comb begin
      vert = ident(s1_mode_ff);
      if (YW'(s1_y_ff) < YW'(s1_h_ff)) begin
         vert = s1_pix_ff;
      end
      for (int j = 1; j <= NLINE; j++) begin
         if ((j <= 2 * int'(s1_r_ff)) && (s1_y_ff >= YW'(j))
             && (s1_y_ff < YW'(s1_h_ff) + YW'(j))) begin
            vert = pick(s1_mode_ff, vert, line_q[j-1]);
         end
      end
   end

   assign tctl.shift_en = adv && s1_valid_ff;
   assign tctl.want_tog = s2_tog_ff;
   assign tctl.mode     = s2_mode_ff;
   assign want_tag      = YW'(s2_or_ff) + YW'(s2_r_ff);

   assign tap_v[0] = 1'b1;
   assign tap_d[0] = vert;
   assign tap_t[0] = s1_y_ff;
   assign tap_g[0] = s1_tog_ff;

   for (genvar k = 0; k < NTAP; k++) begin : g_tap
      gmsw_tap_cell #(
         .CELL_INDEX (k),
         .YW         (YW),
         .RW         (RW)
      ) u_tap (
         .clock    (clock),
         .reset    (reset),
         .ctl      (tctl),
         .want_tag (want_tag),
         .radius   (s2_r_ff),
         .d_valid  (tap_v[k]),
         .d_value  (tap_d[k]),
         .d_tag    (tap_t[k]),
         .d_tog    (tap_g[k]),
         .q_valid  (tap_v[k+1]),
         .q_value  (tap_d[k+1]),
         .q_tag    (tap_t[k+1]),
         .q_tog    (tap_g[k+1]),
         .masked   (tap_m[k])
      );
   end

   always_comb begin
      horz = ident(s2_mode_ff);
      for (int k = 0; k < NTAP; k++) begin
         horz = pick(s2_mode_ff, horz, tap_m[k]);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tlast  = out_last_ff;

   // nothing is emitted while the lag is still counting down
   a_no_output_before_lag: assert property (@(posedge clock) disable iff (reset)
      (!first_ff && lag_ff != '0) |-> (or_ff == '0 && oc_ff == '0))
      else $error("output position moved before lag elapsed");

   // the last result of a frame returns the counters to frame start
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (item_go && last) |=> (first_ff && x_ff == '0 && y_ff == '0))
      else $error("frame did not wrap after last result");

   // the input column counter stays inside the active row once a frame has started
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      !first_ff |-> (WW'(x_ff) < act_w_ff))
      else $error("column counter beyond row width");

endmodule
